// ===== rtl/psf_pkg.sv =====
// Shared constants, types and helpers of the prime sieve filter.
package psf_pkg;

   // Table depth and working width of the arithmetic.
   localparam int MAX_PRIMES  = 64;
   localparam int VALUE_WIDTH = 16;

   // Fixed width of the candidate and prime_value fields on the ports.
   localparam int FIELD_W = 16;

   // Derived widths.
   localparam int COUNT_W = $clog2(MAX_PRIMES + 1);
   localparam int ADDR_W  = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int STEP_W  = $clog2(VALUE_WIDTH + 1);
   localparam int WIDE_W  = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;

   typedef logic [FIELD_W-1:0]     field_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [ADDR_W-1:0]      addr_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_DIV,
      ST_EMIT
   } psf_state_type;

   // Command to the remainder unit.
   typedef struct packed {
      logic      start;
      value_type dividend;
      value_type divisor;
   } psf_div_cmd_type;

   // Status back from the remainder unit.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } psf_div_stat_type;

   // Port field to working width: keep the low VALUE_WIDTH bits.
   function automatic value_type field_to_value(field_type f);
      logic [WIDE_W-1:0] t;
      t = WIDE_W'(f);
      return t[VALUE_WIDTH-1:0];
   endfunction

   // Working value back to the port field width.
   function automatic field_type value_to_field(value_type v);
      logic [WIDE_W-1:0] t;
      t = WIDE_W'(v);
      return t[FIELD_W-1:0];
   endfunction

endpackage

// ===== rtl/psf_if.sv =====
// Valid/ready channel interfaces for candidates and primes.
interface psf_req_if import psf_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface psf_rsp_if import psf_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type prime_value;
   logic      stored;

   modport source (output valid, output prime_value, output stored, input ready);
   modport sink   (input valid, input prime_value, input stored, output ready);
endinterface

// ===== rtl/psf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psf_divider.sv =====
// Restoring remainder unit: one quotient bit per cycle, reports a zero remainder.
module psf_divider import psf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  psf_div_cmd_type  cmd,
   output psf_div_stat_type stat
);

   logic                   busy_ff, busy_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   value_type              rem_ff, rem_in;
   value_type              shift_ff, shift_in;
   value_type              divisor_ff, divisor_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   // Shift in the next dividend bit and try a subtract.
   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         shift_in   = cmd.dividend;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         // remainder stays below divisor, so it fits VALUE_WIDTH bits
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/prime_sieve_filter.sv =====
// Top level of the prime sieve filter: sequencer, prime table and remainder unit.
//
//   channel   dir  beat contents               accepted when
//   req_bus   in   candidate[15:0]             valid && ready
//   rsp_bus   out  prime_value[15:0], stored   valid && ready
//
// A prime passes accept, then for each stored prime tested a table check and
// read, the bit-serial remainder unit and a step, then a last table check and
// emit; up to 64 stored primes are tested when the table is full. A divisible
// candidate ends at the first hit. Candidates 0 and 1 end at accept.
// Reset (synchronous) empties the table by clearing the fill count.
// A finished prime waits in the output register; a new candidate is accepted
// while it waits, and the block stalls only when a second prime is ready.
module prime_sieve_filter import psf_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   psf_req_if.sink   req_bus,
   psf_rsp_if.source rsp_bus
);

   psf_state_type    state_ff, state_in;
   value_type        cand_ff, cand_in;
   count_type        idx_ff, idx_in;
   count_type        count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   field_type        rsp_value_ff, rsp_value_in;
   logic             rsp_stored_ff, rsp_stored_in;

   logic             ram_wr_en;
   logic             ram_rd_en;
   value_type        ram_rd_data;
   psf_div_cmd_type  div_cmd;
   psf_div_stat_type div_stat;
   logic             table_full;
   logic             out_free;

   assign table_full = (count_ff == COUNT_W'(MAX_PRIMES));
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer: walk the table, one remainder per stored prime up to the first hit.
   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_stored_in = rsp_stored_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = cand_ff;
      div_cmd.divisor  = ram_rd_data;
      req_bus.ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               cand_in = field_to_value(req_bus.candidate);
               idx_in  = '0;
               if (field_to_value(req_bus.candidate) >= VALUE_WIDTH'(2)) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (idx_ff == count_ff) begin
               state_in = ST_EMIT;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            div_cmd.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + COUNT_W'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_EMIT: begin
            // prime found: load the output beat and append when there is room
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_to_field(cand_ff);
               rsp_stored_in = !table_full;
               if (!table_full) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + COUNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff       <= cand_in;
      idx_ff        <= idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   // Prime table.
   psf_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_PRIMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (cand_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Shared remainder unit.
   psf_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.prime_value = rsp_value_ff;
   assign rsp_bus.stored      = rsp_stored_ff;

endmodule

// ===== tb/prime_sieve_filter_test.sv =====
// Self-checking testbench for the prime sieve filter: directed and random candidate beats against a table model.
`timescale 1ns / 100ps

module prime_sieve_filter_test import psf_pkg::*; ();

   localparam int unsigned RANDOM_ITEMS = 1480;
   localparam int unsigned HOLD_CYCLES  = 3000;
   localparam int unsigned HOLD_AFTER   = 40;
   // Full table: 64 primes, each with table read, remainder unit and step, plus entry and exit.
   localparam int unsigned DRAIN_CYCLES = MAX_PRIMES * (VALUE_WIDTH + 3) + 100;
   localparam int unsigned IDLE_LIMIT   = 20000;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct {
      field_type value;
      logic      stored;
   } found_prime_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psf_req_if req_bus ();
   psf_rsp_if rsp_bus ();

   prime_sieve_filter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Stimulus and scoreboard state
   field_type       candidates_todo[$];
   found_prime_type primes_due[$];
   value_type       sieve_table[MAX_PRIMES];
   int unsigned     sieve_fill    = 0;
   int unsigned     total_items   = 0;
   int unsigned     items_taken   = 0;
   int unsigned     primes_seen   = 0;
   int unsigned     error_count   = 0;
   int unsigned     items_offered = 0;
   int unsigned     rsp_turns     = 0;
   int unsigned     gap_left      = 0;
   int unsigned     stall_left    = 0;
   int unsigned     hold_left     = 0;
   bit              hold_done     = 1'b0;
   int unsigned     idle_cycles   = 0;

   // Clock: 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap length: mostly none or short, a few long, with calm stretches
   function automatic int unsigned pick_idle(int unsigned beat_no);
      int unsigned r;
      r = $urandom_range(0, 99);
      if ((beat_no % 128) < 32) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   // Trial division against the stored primes; queue the prime if none divides
   function automatic void sieve_candidate(field_type cand);
      value_type       v;
      bit              divides;
      found_prime_type hit;
      v       = value_type'(cand);
      divides = 1'b0;
      if (v < 2) return;
      for (int i = 0; i < sieve_fill; i++)
         if (v % sieve_table[i] == 0) divides = 1'b1;
      if (divides) return;
      hit.value  = field_type'(v);
      hit.stored = (sieve_fill < MAX_PRIMES);
      if (hit.stored) begin
         sieve_table[sieve_fill] = v;
         sieve_fill++;
      end
      primes_due.push_back(hit);
   endfunction

   // Known values before the first edge; hold reset, then release it
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.candidate = '0;
      rsp_bus.ready     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Candidate driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (candidates_todo.size() > 0) begin
            req_bus.valid     <= 1'b1;
            req_bus.candidate <= candidates_todo.pop_front();
            gap_left          <= pick_idle(items_offered);
            items_offered++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Prime receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         hold_left     <= 0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_done && primes_seen >= HOLD_AFTER) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= pick_idle(rsp_turns);
         rsp_turns++;
      end
   end

   // Monitor: check prime beats, then predict from candidate beats
   always @(posedge clock) begin
      found_prime_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            primes_seen++;
            if (primes_due.size() == 0) begin
               note_failure($sformatf("unexpected prime %0d stored %0b",
                                      rsp_bus.prime_value, rsp_bus.stored));
            end else begin
               want = primes_due.pop_front();
               if (rsp_bus.prime_value !== want.value)
                  note_failure($sformatf("prime_value: expected %0d, got %0d",
                                         want.value, rsp_bus.prime_value));
               if (rsp_bus.stored !== want.stored)
                  note_failure($sformatf("stored for %0d: expected %0b, got %0b",
                                         want.value, want.stored, rsp_bus.stored));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            sieve_candidate(req_bus.candidate);
            items_taken++;
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("prime_sieve_filter_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus build and end of run
   initial begin
      field_type   directed[$];
      int unsigned counted;
      int unsigned next_up;
      int unsigned r;
      field_type   cand;

      // Below two, first primes, repeats of stored primes, top values
      directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd2, 16'd5, 16'd6, 16'd7,
                   16'd8, 16'd9, 16'hFFFF, 16'hFFFE, 16'd1, 16'd0, 16'd10, 16'd11,
                   16'd3, 16'd12, 16'd13};
      foreach (directed[i]) candidates_todo.push_back(directed[i]);

      // Mostly the ascending sequence (fills the table past 311), plus noise
      counted = 0;
      next_up = 14;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            cand = field_type'(next_up);
            next_up++;
         end else if (r < 88) begin
            cand = field_type'($urandom_range(0, 65535));
         end else if (r < 93) begin
            cand = field_type'($urandom_range(0, next_up));
         end else if (r < 97) begin
            cand = field_type'($urandom_range(65500, 65535));
         end else begin
            cand = field_type'($urandom_range(0, 1));
         end
         candidates_todo.push_back(cand);
         if (cand >= 2) counted++;
      end
      total_items = candidates_todo.size();

      while (items_taken < total_items) @(posedge clock);
      while (primes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("prime_sieve_filter_test OK");
      end else begin
         $display("prime_sieve_filter_test NOT OK");
      end
      $finish;
   end

endmodule
